/* rtl/core/segerr_pkg.sv */
// shared constants and types of the segmentation error map
`default_nettype none

package segerr_pkg;

    localparam int unsigned LABEL_W = 8;
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned ALPHA_W = 9;
    localparam int unsigned CLS_W   = 2;
    localparam int unsigned CNT_W   = 25;

    localparam int unsigned NUM_CLASSES_DEF = 3;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(141);
    // 1.0 in q8
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(256);

    localparam longint unsigned MAX_FRAME_PIXELS = 64'd16777216;
    localparam longint unsigned CNT_MAX          = (64'd1 << CNT_W) - 64'd1;
    localparam logic [CNT_W-1:0] CNT_CAP =
        (MAX_FRAME_PIXELS > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(MAX_FRAME_PIXELS);

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_STATS = 1'b1;

    localparam logic [PIX_W-1:0] MARK_ON  = '1;
    localparam logic [PIX_W-1:0] MARK_OFF = '0;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_rgb;

    typedef struct packed {
        logic [CNT_W-1:0] hit;
        logic [CNT_W-1:0] false_alarm;
        logic [CNT_W-1:0] miss;
    } t_counts;

endpackage

`default_nettype wire

/* rtl/core/segmentation_error_map_top.sv */
// top level of the segmentation error map with overlay and class statistics
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | sink      | i_in_valid / o_in_ready    | labels, gray level, frame end
//  out     | source    | o_out_valid / i_out_ready  | kind, error and overlay color, counts
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | alpha_q8
//
// one pixel per clock while the output is not stalled and no statistics are being sent;
// a request passes the input register and then the output register before it leaves
// a frame end pixel is followed by NUM_CLASSES statistics results from the counter bank,
// one per cycle unless the output stalls; the input register holds one pixel meanwhile
// i_out_ready low freezes the output register, the input register still takes one pixel
// synchronous reset clears counters and valids and sets alpha_q8 to 141
`default_nettype none

module segmentation_error_map_top #(
    parameter int unsigned NUM_CLASSES = segerr_pkg::NUM_CLASSES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [segerr_pkg::LABEL_W-1:0]   i_predicted_label,
    input  wire logic [segerr_pkg::LABEL_W-1:0]   i_truth_label,
    input  wire logic [segerr_pkg::PIX_W-1:0]     i_gray_level,
    input  wire logic                             i_frame_end,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [segerr_pkg::ALPHA_W-1:0]   i_cfg_alpha_q8,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_result_kind,
    output logic [segerr_pkg::PIX_W-1:0]          o_err_blue,
    output logic [segerr_pkg::PIX_W-1:0]          o_err_green,
    output logic [segerr_pkg::PIX_W-1:0]          o_err_red,
    output logic [segerr_pkg::PIX_W-1:0]          o_over_blue,
    output logic [segerr_pkg::PIX_W-1:0]          o_over_green,
    output logic [segerr_pkg::PIX_W-1:0]          o_over_red,
    output logic [segerr_pkg::CLS_W-1:0]          o_class_index,
    output logic [segerr_pkg::CNT_W-1:0]          o_hit_count,
    output logic [segerr_pkg::CNT_W-1:0]          o_false_alarm_count,
    output logic [segerr_pkg::CNT_W-1:0]          o_miss_count,
    output logic                                  o_last_result
);

    localparam int unsigned IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    // input register
    logic                           r_s1_valid;
    logic [segerr_pkg::LABEL_W-1:0] r_s1_pred;
    logic [segerr_pkg::LABEL_W-1:0] r_s1_truth;
    logic [segerr_pkg::PIX_W-1:0]   r_s1_gray;
    logic                           r_s1_fe;

    logic [segerr_pkg::ALPHA_W-1:0] r_alpha;

    // statistics sequencer
    logic                           r_stat_active;
    logic [IDX_W-1:0]               r_stat_idx;
    logic                           stat_last;
    logic [IDX_W:0]                 stat_num;

    // output register
    logic                           r_out_valid;
    logic                           r_out_kind;
    segerr_pkg::t_rgb               r_out_err;
    segerr_pkg::t_rgb               r_out_over;
    logic [segerr_pkg::CLS_W-1:0]   r_out_class;
    segerr_pkg::t_counts            r_out_counts;
    logic                           r_out_last;

    logic                           out_load;
    logic                           pix_load;
    logic                           stat_load;

    segerr_pkg::t_rgb               pix_err;
    segerr_pkg::t_rgb               pix_over;
    logic [NUM_CLASSES-1:0]         pix_hit;
    logic [NUM_CLASSES-1:0]         pix_fa;
    logic [NUM_CLASSES-1:0]         pix_miss;
    segerr_pkg::t_counts            sel_counts;

    assign out_load   = !r_out_valid || i_out_ready;
    assign stat_load  = out_load && r_stat_active;
    assign pix_load   = out_load && !r_stat_active && r_s1_valid;
    assign o_in_ready = !r_s1_valid || pix_load;
    assign o_cfg_ready = 1'b1;

    assign stat_last = (r_stat_idx == IDX_W'(NUM_CLASSES - 1));
    assign stat_num  = {1'b0, r_stat_idx} + (IDX_W + 1)'(1);

    segerr_pixel #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_pixel (
        .i_predicted_label (r_s1_pred),
        .i_truth_label     (r_s1_truth),
        .i_gray_level      (r_s1_gray),
        .i_alpha_q8        (r_alpha),
        .o_err             (pix_err),
        .o_over            (pix_over),
        .o_hit             (pix_hit),
        .o_false_alarm     (pix_fa),
        .o_miss            (pix_miss)
    );

    segerr_counters #(
        .NUM_CLASSES (NUM_CLASSES),
        .IDX_W       (IDX_W)
    ) u_counters (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_count_en    (pix_load),
        .i_hit         (pix_hit),
        .i_false_alarm (pix_fa),
        .i_miss        (pix_miss),
        .i_clear       (stat_load),
        .i_sel         (r_stat_idx),
        .o_counts      (sel_counts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= segerr_pkg::ALPHA_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_alpha <= i_cfg_alpha_q8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_pred  <= i_predicted_label;
            r_s1_truth <= i_truth_label;
            r_s1_gray  <= i_gray_level;
            r_s1_fe    <= i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat_active <= 1'b0;
            r_stat_idx    <= '0;
        end else if (stat_load) begin
            if (stat_last) begin
                r_stat_active <= 1'b0;
                r_stat_idx    <= '0;
            end else begin
                r_stat_idx <= r_stat_idx + 1'b1;
            end
        end else if (pix_load && r_s1_fe) begin
            r_stat_active <= 1'b1;
            r_stat_idx    <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_stat_active || r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat_load) begin
            r_out_kind   <= segerr_pkg::KIND_STATS;
            r_out_err    <= '0;
            r_out_over   <= '0;
            r_out_class  <= stat_num[segerr_pkg::CLS_W-1:0];
            r_out_counts <= sel_counts;
            r_out_last   <= stat_last;
        end else if (pix_load) begin
            r_out_kind   <= segerr_pkg::KIND_PIXEL;
            r_out_err    <= pix_err;
            r_out_over   <= pix_over;
            r_out_class  <= '0;
            r_out_counts <= '0;
            r_out_last   <= !r_s1_fe;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_result_kind       = r_out_kind;
    assign o_err_blue          = r_out_err.blue;
    assign o_err_green         = r_out_err.green;
    assign o_err_red           = r_out_err.red;
    assign o_over_blue         = r_out_over.blue;
    assign o_over_green        = r_out_over.green;
    assign o_over_red          = r_out_over.red;
    assign o_class_index       = r_out_class;
    assign o_hit_count         = r_out_counts.hit;
    assign o_false_alarm_count = r_out_counts.false_alarm;
    assign o_miss_count        = r_out_counts.miss;
    assign o_last_result       = r_out_last;

endmodule

`default_nettype wire

/* rtl/core/segerr_pixel.sv */
// per-pixel class marks, error color and alpha blended overlay
`default_nettype none

module segerr_pixel #(
    parameter int unsigned NUM_CLASSES = segerr_pkg::NUM_CLASSES_DEF
) (
    input  wire logic [segerr_pkg::LABEL_W-1:0] i_predicted_label,
    input  wire logic [segerr_pkg::LABEL_W-1:0] i_truth_label,
    input  wire logic [segerr_pkg::PIX_W-1:0]   i_gray_level,
    input  wire logic [segerr_pkg::ALPHA_W-1:0] i_alpha_q8,
    output segerr_pkg::t_rgb                    o_err,
    output segerr_pkg::t_rgb                    o_over,
    output logic [NUM_CLASSES-1:0]              o_hit,
    output logic [NUM_CLASSES-1:0]              o_false_alarm,
    output logic [NUM_CLASSES-1:0]              o_miss
);

    localparam int unsigned SUM_W = 2 * segerr_pkg::PIX_W + 1;

    logic                           pm;
    logic                           tm;
    logic [segerr_pkg::ALPHA_W-1:0] alpha;
    logic [segerr_pkg::ALPHA_W-1:0] inv_alpha;
    logic [SUM_W-1:0]               base;
    logic [SUM_W-1:0]               err_term;
    logic [SUM_W-1:0]               sum_b;
    logic [SUM_W-1:0]               sum_g;
    logic [SUM_W-1:0]               sum_r;
    logic                           any_err;

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            pm = (i_predicted_label == segerr_pkg::LABEL_W'(c + 1));
            tm = (i_truth_label == segerr_pkg::LABEL_W'(c + 1));
            o_hit[c]         = pm && tm;
            o_false_alarm[c] = pm && !tm;
            o_miss[c]        = !pm && tm;
        end
    end

    assign o_err.green = (|o_hit)         ? segerr_pkg::MARK_ON : segerr_pkg::MARK_OFF;
    assign o_err.red   = (|o_false_alarm) ? segerr_pkg::MARK_ON : segerr_pkg::MARK_OFF;
    assign o_err.blue  = (|o_miss)        ? segerr_pkg::MARK_ON : segerr_pkg::MARK_OFF;
    assign any_err     = (|o_hit) || (|o_false_alarm) || (|o_miss);

    assign alpha     = (i_alpha_q8 > segerr_pkg::ALPHA_ONE) ? segerr_pkg::ALPHA_ONE
                                                            : i_alpha_q8;
    assign inv_alpha = segerr_pkg::ALPHA_ONE - alpha;

    // (256-a)*gray + 128 is shared by all channels, a marked channel adds a*255
    assign base     = SUM_W'(inv_alpha) * SUM_W'(i_gray_level) + SUM_W'(128);
    assign err_term = SUM_W'({alpha, 8'b0}) - SUM_W'(alpha);

    assign sum_b = base + ((|o_miss)        ? err_term : '0);
    assign sum_g = base + ((|o_hit)         ? err_term : '0);
    assign sum_r = base + ((|o_false_alarm) ? err_term : '0);

    // sums never exceed 255*256+128, so no clamp is needed
    assign o_over.blue  = any_err ? sum_b[2*segerr_pkg::PIX_W-1:segerr_pkg::PIX_W]
                                  : i_gray_level;
    assign o_over.green = any_err ? sum_g[2*segerr_pkg::PIX_W-1:segerr_pkg::PIX_W]
                                  : i_gray_level;
    assign o_over.red   = any_err ? sum_r[2*segerr_pkg::PIX_W-1:segerr_pkg::PIX_W]
                                  : i_gray_level;

endmodule

`default_nettype wire

/* rtl/core/segerr_counters.sv */
// saturating per-class hit, false alarm and miss counters
`default_nettype none

module segerr_counters #(
    parameter int unsigned NUM_CLASSES = segerr_pkg::NUM_CLASSES_DEF,
    parameter int unsigned IDX_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_count_en,
    input  wire logic [NUM_CLASSES-1:0] i_hit,
    input  wire logic [NUM_CLASSES-1:0] i_false_alarm,
    input  wire logic [NUM_CLASSES-1:0] i_miss,
    input  wire logic                   i_clear,
    input  wire logic [IDX_W-1:0]       i_sel,
    output segerr_pkg::t_counts         o_counts
);

    logic [segerr_pkg::CNT_W-1:0] r_hit  [NUM_CLASSES];
    logic [segerr_pkg::CNT_W-1:0] r_fa   [NUM_CLASSES];
    logic [segerr_pkg::CNT_W-1:0] r_miss [NUM_CLASSES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_hit[c]  <= '0;
                r_fa[c]   <= '0;
                r_miss[c] <= '0;
            end
        end else begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (i_clear && (i_sel == IDX_W'(c))) begin
                    r_hit[c]  <= '0;
                    r_fa[c]   <= '0;
                    r_miss[c] <= '0;
                end else if (i_count_en) begin
                    if (i_hit[c] && (r_hit[c] < segerr_pkg::CNT_CAP)) begin
                        r_hit[c] <= r_hit[c] + 1'b1;
                    end
                    if (i_false_alarm[c] && (r_fa[c] < segerr_pkg::CNT_CAP)) begin
                        r_fa[c] <= r_fa[c] + 1'b1;
                    end
                    if (i_miss[c] && (r_miss[c] < segerr_pkg::CNT_CAP)) begin
                        r_miss[c] <= r_miss[c] + 1'b1;
                    end
                end
            end
        end
    end

    assign o_counts.hit         = r_hit[i_sel];
    assign o_counts.false_alarm = r_fa[i_sel];
    assign o_counts.miss        = r_miss[i_sel];

endmodule

`default_nettype wire

/* rtl/core/segerr_checker.sv */
// port-level checks of the segmentation error map and their binding
`default_nettype none

module segerr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_result_kind,
    input wire logic [7:0] o_err_blue,
    input wire logic [7:0] o_err_green,
    input wire logic [7:0] o_err_red,
    input wire logic [7:0] o_over_blue,
    input wire logic [7:0] o_over_green,
    input wire logic [7:0] o_over_red,
    input wire logic [1:0] o_class_index,
    input wire logic [24:0] o_hit_count,
    input wire logic [24:0] o_false_alarm_count,
    input wire logic [24:0] o_miss_count,
    input wire logic       o_last_result
);

    // a stalled result stays valid and keeps its kind, hit count, red overlay and last flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_kind)
            && $stable(o_hit_count) && $stable(o_over_red) && $stable(o_last_result))
        else $error("output changed while stalled");

    // an accepted result that is not marked last is followed at once by a statistics result
    a_stats_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_result |=> o_out_valid && o_result_kind)
        else $error("statistics burst broken");

    // pixel results carry no counts
    a_pixel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result_kind |-> o_class_index == 2'd0 && o_hit_count == 25'd0
            && o_false_alarm_count == 25'd0 && o_miss_count == 25'd0)
        else $error("pixel result with counts");

    // no error mark means the overlay is plain gray
    a_gray_overlay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result_kind && o_err_blue == 8'd0 && o_err_green == 8'd0
            && o_err_red == 8'd0 |-> o_over_blue == o_over_green && o_over_green == o_over_red)
        else $error("overlay not gray without error");

endmodule

bind segmentation_error_map_top segerr_checker u_segerr_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_result_kind       (o_result_kind),
    .o_err_blue          (o_err_blue),
    .o_err_green         (o_err_green),
    .o_err_red           (o_err_red),
    .o_over_blue         (o_over_blue),
    .o_over_green        (o_over_green),
    .o_over_red          (o_over_red),
    .o_class_index       (o_class_index),
    .o_hit_count         (o_hit_count),
    .o_false_alarm_count (o_false_alarm_count),
    .o_miss_count        (o_miss_count),
    .o_last_result       (o_last_result)
);

`default_nettype wire
